FILE: rtl/ebg_pkg.sv
// ---------------------------------------------------------------------------
// ebg_pkg
// shared types, constants and the fixed block template for the EDID base
// block generator
// ---------------------------------------------------------------------------
package ebg_pkg;

   localparam int BYTE_W      = 8;
   localparam int WORD_W      = 64;
   localparam int BLOCK_WORDS = 16;
   localparam int BLOCK_BYTES = 128;
   localparam int WORD_IDX_W  = 4;
   localparam int BLOCK_ADDR_W = 7;
   localparam int DTD_BYTES   = 18;
   localparam int CSR_DATA_W  = 16;
   localparam int MM_W        = 11;

   localparam logic [WORD_IDX_W-1:0] LAST_WORD_INDEX = WORD_IDX_W'(BLOCK_WORDS - 1);

   // byte positions of the variable fields
   localparam int BYTE_MFG_HI   = 8;
   localparam int BYTE_MFG_LO   = 9;
   localparam int BYTE_PROD_LO  = 10;
   localparam int BYTE_PROD_HI  = 11;
   localparam int BYTE_SIZE_H   = 20;
   localparam int BYTE_SIZE_V   = 21;
   localparam int DTD_BASE      = 54;

   localparam logic [CSR_DATA_W-1:0] MANUFACTURER_ID_RESET = 16'h16C3;
   localparam logic [CSR_DATA_W-1:0] PRODUCT_CODE_RESET    = 16'h1234;

   // size in mm: (px * 2646 + 5000) / 10000, division by reciprocal
   localparam logic [23:0] MM_SCALE       = 24'd2646;
   localparam logic [23:0] MM_ROUND       = 24'd5000;
   localparam logic [47:0] MM_RECIP       = 48'd13743896;
   localparam int          MM_RECIP_SHIFT = 37;
   localparam logic [MM_W-1:0] WIDTH_MM_MIN  = 11'd160;
   localparam logic [MM_W-1:0] HEIGHT_MM_MIN = 11'd90;

   // mm / 10 by reciprocal
   localparam logic [21:0] DIV10_RECIP = 22'd1639;
   localparam int          DIV10_SHIFT = 14;

   localparam logic [BYTE_W-1:0] DTD_FLAGS_BASE = 8'h18;

   typedef enum logic [0:0] {
      CSR_MANUFACTURER_ID = 1'b0,
      CSR_PRODUCT_CODE    = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [15:0] pixel_rate_10k;
      logic [11:0] h_active;
      logic [12:0] h_sync_begin;
      logic [12:0] h_sync_finish;
      logic [12:0] h_period;
      logic [11:0] v_active;
      logic [12:0] v_sync_begin;
      logic [12:0] v_sync_finish;
      logic [12:0] v_period;
      logic        h_polarity_pos;
      logic        v_polarity_pos;
   } req_type;

   typedef struct packed {
      logic [63:0]           block_word;
      logic [WORD_IDX_W-1:0] word_index;
      logic                  last_word;
   } rsp_type;

   // timing values reduced to the descriptor's field widths
   typedef struct packed {
      logic [15:0] clk;
      logic [11:0] h_active;
      logic [11:0] v_active;
      logic [11:0] h_blank;
      logic [11:0] v_blank;
      logic [9:0]  h_offset;
      logic [9:0]  h_pulse;
      logic [5:0]  v_offset;
      logic [5:0]  v_pulse;
      logic        h_pol;
      logic        v_pol;
   } timing_type;

   // fixed bytes of the block, variable positions read as zero
   function automatic logic [BYTE_W-1:0] template_byte(input logic [BLOCK_ADDR_W-1:0] addr);
      logic [BYTE_W-1:0] b;
      b = 8'h00;
      case (addr)
         7'd1, 7'd2, 7'd3, 7'd4, 7'd5, 7'd6: b = 8'hFF;
         7'd12, 7'd17: b = 8'h01;
         7'd16: b = 8'h1A;
         7'd18: b = 8'h03;
         7'd19: b = 8'h80;
         7'd22: b = 8'h78;
         7'd23: b = 8'h0A;
         7'd24: b = 8'hEE;
         7'd25: b = 8'h95;
         7'd26: b = 8'hA3;
         7'd27: b = 8'h54;
         7'd28: b = 8'h4C;
         7'd29: b = 8'h99;
         7'd30: b = 8'h26;
         7'd31: b = 8'h0F;
         7'd75: b = 8'hFC;
         7'd77: b = 8'h45;
         7'd78: b = 8'h56;
         7'd79: b = 8'h44;
         7'd80: b = 8'h49;
         7'd81, 7'd89: b = 8'h20;
         7'd82: b = 8'h56;
         7'd83: b = 8'h69;
         7'd84: b = 8'h72;
         7'd85: b = 8'h74;
         7'd86: b = 8'h75;
         7'd87: b = 8'h61;
         7'd88: b = 8'h6C;
         7'd93: b = 8'hFF;
         7'd95: b = 8'h45;
         7'd96: b = 8'h56;
         7'd97, 7'd98, 7'd99, 7'd100, 7'd101: b = 8'h30;
         7'd102: b = 8'h31;
         7'd103: b = 8'h0A;
         7'd104, 7'd105, 7'd106, 7'd107: b = 8'h20;
         7'd111: b = 8'hFD;
         7'd113: b = 8'h18;
         7'd114: b = 8'h90;
         7'd115: b = 8'h0F;
         7'd116: b = 8'hFF;
         7'd117: b = 8'h3C;
         7'd118: b = 8'h01;
         7'd119: b = 8'h0A;
         7'd120, 7'd121, 7'd122, 7'd123, 7'd124, 7'd125: b = 8'h20;
         default: begin
            if (addr >= 7'd36 && addr <= 7'd53) b = 8'h01;
         end
      endcase
      return b;
   endfunction

endpackage

FILE: rtl/ebg_serializer.sv
// ---------------------------------------------------------------------------
// ebg_serializer
// holds one assembled block and sends it as sixteen words, one per cycle when
// not stalled, summing bytes on the way to fill in the last word's checksum
// ---------------------------------------------------------------------------
module ebg_serializer (
   input  logic clock,
   input  logic reset,
   input  logic load_valid,
   output logic load_ready,
   input  logic [ebg_pkg::BLOCK_WORDS-1:0][ebg_pkg::WORD_W-1:0] load_block,
   output logic rsp_valid,
   input  logic rsp_stall,
   output ebg_pkg::rsp_type rsp_data
);

   logic busy_ff, busy_in;
   logic [ebg_pkg::WORD_IDX_W-1:0] index_ff, index_in;
   logic [ebg_pkg::BLOCK_WORDS-1:0][ebg_pkg::WORD_W-1:0] block_ff, block_in;
   logic [ebg_pkg::BYTE_W-1:0] sum_ff, sum_in;

   logic [ebg_pkg::WORD_W-1:0] word;
   logic [ebg_pkg::BYTE_W-1:0] word_sum;
   logic [ebg_pkg::BYTE_W-1:0] checksum;
   logic last;
   logic send;
   logic load;

   assign word = block_ff[index_ff];
   assign last = (index_ff == ebg_pkg::LAST_WORD_INDEX);
   assign send = busy_ff && !rsp_stall;
   assign load_ready = !busy_ff || (send && last);
   assign load = load_valid && load_ready;

   always_comb begin
      word_sum = '0;
      for (int i = 0; i < ebg_pkg::WORD_W / ebg_pkg::BYTE_W; i++) begin
         word_sum = word_sum + word[ebg_pkg::BYTE_W*i +: ebg_pkg::BYTE_W];
      end
   end

   // the checksum byte of the block is stored as zero
   assign checksum = 8'd0 - (sum_ff + word_sum);

   always_comb begin
      busy_in  = busy_ff;
      index_in = index_ff;
      block_in = block_ff;
      sum_in   = sum_ff;
      if (load) begin
         busy_in  = 1'b1;
         index_in = '0;
         block_in = load_block;
         sum_in   = '0;
      end else if (send) begin
         if (last) busy_in = 1'b0;
         index_in = index_ff + 1'b1;
         sum_in   = sum_ff + word_sum;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
   end

   always_ff @(posedge clock) begin
      index_ff <= index_in;
      block_ff <= block_in;
      sum_ff   <= sum_in;
   end

   assign rsp_valid = busy_ff;
   assign rsp_data.block_word = last ?
      {checksum, word[ebg_pkg::WORD_W-ebg_pkg::BYTE_W-1:0]} : word;
   assign rsp_data.word_index = index_ff;
   assign rsp_data.last_word  = last;

endmodule

FILE: rtl/edid_base_block_generator.sv
// ---------------------------------------------------------------------------
// edid_base_block_generator
// builds the 128-byte EDID base block for one display timing and sends it
// as sixteen 64-bit words
//
//   port group   direction   transaction
//   req_*        in          one display timing, valid/stall
//   rsp_*        out         one block word with index and last flag, valid/stall
//   csr_*        in          register write, taken on csr_wr_en
//
// four register stages (input register, differences and scaling products,
// division to mm, clamp and descriptor packing) feed block assembly and the
// word serializer, which sets the rate: one word per cycle while rsp_stall is
// low. the first word is valid once a timing has passed stages 1 to 4 and been
// loaded into the serializer. reset clears stage valid bits and the serializer
// and loads the register reset values. rsp_stall holds the current word and
// backs up the stages; req_stall rises once stage 1 is full and cannot move on.
// ---------------------------------------------------------------------------
module edid_base_block_generator (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  ebg_pkg::req_type req_data,
   output logic rsp_valid,
   input  logic rsp_stall,
   output ebg_pkg::rsp_type rsp_data,
   input  logic csr_wr_en,
   input  ebg_pkg::csr_index_type csr_index,
   input  logic [ebg_pkg::CSR_DATA_W-1:0] csr_wdata
);

   logic [ebg_pkg::CSR_DATA_W-1:0] mfg_id_ff, mfg_id_in;
   logic [ebg_pkg::CSR_DATA_W-1:0] prod_code_ff, prod_code_in;

   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic s3_valid_ff, s3_valid_in;
   logic s4_valid_ff, s4_valid_in;
   logic s1_en, s2_en, s3_en, s4_en;

   ebg_pkg::req_type    s1_req_ff, s1_req_in;
   ebg_pkg::timing_type s2_tim_ff, s2_tim_in;
   logic [23:0]         s2_h_prod_ff, s2_h_prod_in;
   logic [23:0]         s2_v_prod_ff, s2_v_prod_in;
   ebg_pkg::timing_type s3_tim_ff;
   logic [ebg_pkg::MM_W-1:0] s3_w_raw_ff, s3_w_raw_in;
   logic [ebg_pkg::MM_W-1:0] s3_h_raw_ff, s3_h_raw_in;
   logic [ebg_pkg::DTD_BYTES-1:0][ebg_pkg::BYTE_W-1:0] s4_dtd_ff, s4_dtd_in;
   logic [ebg_pkg::BYTE_W-1:0] s4_size_h_ff, s4_size_h_in;
   logic [ebg_pkg::BYTE_W-1:0] s4_size_v_ff, s4_size_v_in;

   logic [23:0] w_round, h_round;
   logic [47:0] w_quot, h_quot;
   logic [ebg_pkg::MM_W-1:0] w_mm, h_mm;
   logic [21:0] w_tenth, h_tenth;

   logic [ebg_pkg::BLOCK_BYTES-1:0][ebg_pkg::BYTE_W-1:0] block_bytes;
   logic ser_ready;

   // registers
   always_comb begin
      mfg_id_in    = mfg_id_ff;
      prod_code_in = prod_code_ff;
      if (csr_wr_en) begin
         case (csr_index)
            ebg_pkg::CSR_MANUFACTURER_ID: mfg_id_in    = csr_wdata;
            ebg_pkg::CSR_PRODUCT_CODE:    prod_code_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mfg_id_ff    <= ebg_pkg::MANUFACTURER_ID_RESET;
         prod_code_ff <= ebg_pkg::PRODUCT_CODE_RESET;
      end else begin
         mfg_id_ff    <= mfg_id_in;
         prod_code_ff <= prod_code_in;
      end
   end

   // stage enables
   assign s4_en = !s4_valid_ff || ser_ready;
   assign s3_en = !s3_valid_ff || s4_en;
   assign s2_en = !s2_valid_ff || s3_en;
   assign s1_en = !s1_valid_ff || s2_en;
   assign req_stall = !s1_en;

   assign s1_valid_in = s1_en ? req_valid   : s1_valid_ff;
   assign s2_valid_in = s2_en ? s1_valid_ff : s2_valid_ff;
   assign s3_valid_in = s3_en ? s2_valid_ff : s3_valid_ff;
   assign s4_valid_in = s4_en ? s3_valid_ff : s4_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
         s4_valid_ff <= s4_valid_in;
      end
   end

   // stage 1: input register
   assign s1_req_in = req_data;

   // stage 2: wrapped differences and scaling products
   always_comb begin
      s2_tim_in.clk      = s1_req_ff.pixel_rate_10k;
      s2_tim_in.h_active = s1_req_ff.h_active;
      s2_tim_in.v_active = s1_req_ff.v_active;
      s2_tim_in.h_blank  = s1_req_ff.h_period[11:0] - s1_req_ff.h_active;
      s2_tim_in.v_blank  = s1_req_ff.v_period[11:0] - s1_req_ff.v_active;
      s2_tim_in.h_offset = s1_req_ff.h_sync_begin[9:0] - s1_req_ff.h_active[9:0];
      s2_tim_in.h_pulse  = s1_req_ff.h_sync_finish[9:0] - s1_req_ff.h_sync_begin[9:0];
      s2_tim_in.v_offset = s1_req_ff.v_sync_begin[5:0] - s1_req_ff.v_active[5:0];
      s2_tim_in.v_pulse  = s1_req_ff.v_sync_finish[5:0] - s1_req_ff.v_sync_begin[5:0];
      s2_tim_in.h_pol    = s1_req_ff.h_polarity_pos;
      s2_tim_in.v_pol    = s1_req_ff.v_polarity_pos;
   end

   assign s2_h_prod_in = {12'd0, s1_req_ff.h_active} * ebg_pkg::MM_SCALE;
   assign s2_v_prod_in = {12'd0, s1_req_ff.v_active} * ebg_pkg::MM_SCALE;

   // stage 3: round and divide by 10000
   assign w_round = s2_h_prod_ff + ebg_pkg::MM_ROUND;
   assign h_round = s2_v_prod_ff + ebg_pkg::MM_ROUND;
   assign w_quot  = {24'd0, w_round} * ebg_pkg::MM_RECIP;
   assign h_quot  = {24'd0, h_round} * ebg_pkg::MM_RECIP;
   assign s3_w_raw_in = w_quot[ebg_pkg::MM_RECIP_SHIFT +: ebg_pkg::MM_W];
   assign s3_h_raw_in = h_quot[ebg_pkg::MM_RECIP_SHIFT +: ebg_pkg::MM_W];

   // stage 4: clamp, size bytes and descriptor packing
   assign w_mm = (s3_w_raw_ff < ebg_pkg::WIDTH_MM_MIN)  ? ebg_pkg::WIDTH_MM_MIN  : s3_w_raw_ff;
   assign h_mm = (s3_h_raw_ff < ebg_pkg::HEIGHT_MM_MIN) ? ebg_pkg::HEIGHT_MM_MIN : s3_h_raw_ff;
   assign w_tenth = {11'd0, w_mm} * ebg_pkg::DIV10_RECIP;
   assign h_tenth = {11'd0, h_mm} * ebg_pkg::DIV10_RECIP;
   assign s4_size_h_in = w_tenth[ebg_pkg::DIV10_SHIFT +: ebg_pkg::BYTE_W];
   assign s4_size_v_in = h_tenth[ebg_pkg::DIV10_SHIFT +: ebg_pkg::BYTE_W];

   always_comb begin
      s4_dtd_in[0]  = s3_tim_ff.clk[7:0];
      s4_dtd_in[1]  = s3_tim_ff.clk[15:8];
      s4_dtd_in[2]  = s3_tim_ff.h_active[7:0];
      s4_dtd_in[3]  = s3_tim_ff.h_blank[7:0];
      s4_dtd_in[4]  = {s3_tim_ff.h_active[11:8], s3_tim_ff.h_blank[11:8]};
      s4_dtd_in[5]  = s3_tim_ff.v_active[7:0];
      s4_dtd_in[6]  = s3_tim_ff.v_blank[7:0];
      s4_dtd_in[7]  = {s3_tim_ff.v_active[11:8], s3_tim_ff.v_blank[11:8]};
      s4_dtd_in[8]  = s3_tim_ff.h_offset[7:0];
      s4_dtd_in[9]  = s3_tim_ff.h_pulse[7:0];
      s4_dtd_in[10] = {s3_tim_ff.v_offset[3:0], s3_tim_ff.v_pulse[3:0]};
      s4_dtd_in[11] = {s3_tim_ff.h_offset[9:8], s3_tim_ff.h_pulse[9:8],
                       s3_tim_ff.v_offset[5:4], s3_tim_ff.v_pulse[5:4]};
      s4_dtd_in[12] = w_mm[7:0];
      s4_dtd_in[13] = h_mm[7:0];
      s4_dtd_in[14] = {1'b0, w_mm[10:8], 1'b0, h_mm[10:8]};
      s4_dtd_in[15] = 8'h00;
      s4_dtd_in[16] = 8'h00;
      s4_dtd_in[17] = ebg_pkg::DTD_FLAGS_BASE |
                      {5'd0, s3_tim_ff.v_pol, s3_tim_ff.h_pol, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (s1_en) s1_req_ff <= s1_req_in;
      if (s2_en) begin
         s2_tim_ff    <= s2_tim_in;
         s2_h_prod_ff <= s2_h_prod_in;
         s2_v_prod_ff <= s2_v_prod_in;
      end
      if (s3_en) begin
         s3_tim_ff   <= s2_tim_ff;
         s3_w_raw_ff <= s3_w_raw_in;
         s3_h_raw_ff <= s3_h_raw_in;
      end
      if (s4_en) begin
         s4_dtd_ff    <= s4_dtd_in;
         s4_size_h_ff <= s4_size_h_in;
         s4_size_v_ff <= s4_size_v_in;
      end
   end

   // block assembly
   always_comb begin
      for (int i = 0; i < ebg_pkg::BLOCK_BYTES; i++) begin
         block_bytes[i] = ebg_pkg::template_byte(ebg_pkg::BLOCK_ADDR_W'(i));
      end
      block_bytes[ebg_pkg::BYTE_MFG_HI]  = mfg_id_ff[15:8];
      block_bytes[ebg_pkg::BYTE_MFG_LO]  = mfg_id_ff[7:0];
      block_bytes[ebg_pkg::BYTE_PROD_LO] = prod_code_ff[7:0];
      block_bytes[ebg_pkg::BYTE_PROD_HI] = prod_code_ff[15:8];
      block_bytes[ebg_pkg::BYTE_SIZE_H]  = s4_size_h_ff;
      block_bytes[ebg_pkg::BYTE_SIZE_V]  = s4_size_v_ff;
      for (int i = 0; i < ebg_pkg::DTD_BYTES; i++) begin
         block_bytes[ebg_pkg::DTD_BASE + i] = s4_dtd_ff[i];
      end
   end

   ebg_serializer u_serializer (
      .clock      (clock),
      .reset      (reset),
      .load_valid (s4_valid_ff),
      .load_ready (ser_ready),
      .load_block (block_bytes),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );

endmodule
